// ===== design/wtc_pkg.sv =====
// Shared types and constants for the waypoint tracking controller.
`default_nettype none
package wtc_pkg;

    // Angle constants, Q2.13
    localparam logic signed [17:0] ANG_PI      = 18'sd25736;
    localparam logic signed [17:0] ANG_HALF_PI = 18'sd12868;
    localparam logic signed [17:0] ANG_TWO_PI  = 18'sd51472;
    localparam int unsigned CORDIC_STEPS = 14;
    localparam logic signed [15:0] CORDIC_INV_GAIN = 16'sd9949;
    localparam logic signed [16:0] SINE_ONE = 17'sd16384;

    // Configuration register indexes
    localparam logic [2:0] REG_GAIN_LINEAR  = 3'd0;
    localparam logic [2:0] REG_GAIN_BRG_P   = 3'd1;
    localparam logic [2:0] REG_GAIN_BRG_D   = 3'd2;
    localparam logic [2:0] REG_GAIN_CTE_P   = 3'd3;
    localparam logic [2:0] REG_GAIN_CTE_D   = 3'd4;
    localparam logic [2:0] REG_SPEED_LIMIT  = 3'd5;
    localparam logic [2:0] REG_TURN_LIMIT   = 3'd6;
    localparam logic [2:0] REG_ACCEPT_RAD   = 3'd7;

    // Datapath phase codes
    typedef enum logic [2:0] {
        PH_LOAD  = 3'd0,
        PH_ROOT  = 3'd1,
        PH_ATAN  = 3'd2,
        PH_SINE  = 3'd3,
        PH_MUL   = 3'd4,
        PH_FIN   = 3'd5
    } phase_t;

    // Controller to datapath commands
    typedef struct packed {
        logic   start;   // capture sample operands
        phase_t phase;
        logic   step;    // advance iterative unit
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic unit_done;
    } dp_stat_t;

    // CORDIC arctangent table, Q2.13
    function automatic logic [12:0] atan_step(input logic [3:0] i);
        logic [12:0] r;
        begin
            case (i)
                4'd0:  r = 13'd6434;
                4'd1:  r = 13'd3798;
                4'd2:  r = 13'd2007;
                4'd3:  r = 13'd1019;
                4'd4:  r = 13'd511;
                4'd5:  r = 13'd256;
                4'd6:  r = 13'd128;
                4'd7:  r = 13'd64;
                4'd8:  r = 13'd32;
                4'd9:  r = 13'd16;
                4'd10: r = 13'd8;
                4'd11: r = 13'd4;
                4'd12: r = 13'd2;
                4'd13: r = 13'd1;
                default: r = 13'd0;
            endcase
            return r;
        end
    endfunction

    // Wrap an angle known to be within (-3pi, 3pi) into [-pi, pi)
    function automatic logic signed [15:0] wrap3(input logic signed [18:0] a);
        logic signed [18:0] r;
        begin
            r = a;
            if (r >= 19'(ANG_PI)) r = r - 19'(ANG_TWO_PI);
            else if (r < -19'(ANG_PI)) r = r + 19'(ANG_TWO_PI);
            return r[15:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== design/wtc_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module wtc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/wtc_datapath.sv =====
// Datapath: difference, square root, atan2 and sine CORDIC, gains and clamps.
`default_nettype none
module wtc_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wtc_pkg::dp_cmd_t    cmd,
    output wtc_pkg::dp_stat_t        stat,
    // operands
    input  wire logic signed [31:0]  wp_x,
    input  wire logic signed [31:0]  wp_y,
    input  wire logic signed [31:0]  robot_x,
    input  wire logic signed [31:0]  robot_y,
    input  wire logic signed [15:0]  robot_heading,
    input  wire logic signed [15:0]  prev_heading,
    input  wire logic [15:0]         gain_linear,
    input  wire logic [15:0]         gain_bearing_p,
    input  wire logic [15:0]         gain_bearing_d,
    input  wire logic [15:0]         gain_crosstrack_p,
    input  wire logic [15:0]         gain_crosstrack_d,
    input  wire logic [30:0]         speed_limit,
    input  wire logic [14:0]         turn_limit,
    // results
    output logic [30:0]              wp_dist,
    output logic [30:0]              speed,
    output logic signed [15:0]       turn
);
    logic signed [32:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [65:0]        rv_reg, rv_next;   // radicand remainder
    logic [65:0]        rr_reg, rr_next;   // root
    logic [65:0]        rb_reg, rb_next;   // root bit
    logic               halved_reg, halved_next;
    logic [30:0]        dist_reg, dist_next;
    logic signed [35:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [18:0] cz_reg, cz_next;
    logic [3:0]         it_reg, it_next;
    logic               norm_reg, norm_next;
    logic signed [15:0] los_reg, los_next;
    logic               sneg_reg, sneg_next;
    logic signed [16:0] sine_reg, sine_next;
    logic signed [47:0] cte_prod_reg, cte_prod_next;
    logic [46:0]        spd_prod_reg, spd_prod_next;
    logic signed [36:0] los_term_reg, los_term_next;
    logic [1:0]         mul_ph_reg, mul_ph_next;
    logic               done_reg, done_next;
    logic [30:0]        speed_reg, speed_next;
    logic signed [15:0] turn_reg, turn_next;

    logic [32:0]        ax, ay;
    logic [31:0]        hx, hy;
    logic               halve;
    logic signed [35:0] xs, ys;
    logic signed [18:0] ang;
    logic signed [32:0] cte_v;
    logic signed [52:0] acc;
    logic signed [37:0] tsh;
    logic [46:0]        sp_sh;
    logic [66:0]        tsum;

    assign stat.unit_done = done_reg;
    assign wp_dist = dist_reg;
    assign speed = speed_reg;
    assign turn  = turn_reg;

    always_comb
    begin
        dx_next = dx_reg; dy_next = dy_reg;
        rv_next = rv_reg; rr_next = rr_reg; rb_next = rb_reg;
        halved_next = halved_reg; dist_next = dist_reg;
        cx_next = cx_reg; cy_next = cy_reg; cz_next = cz_reg;
        it_next = it_reg; norm_next = norm_reg;
        los_next = los_reg; sneg_next = sneg_reg; sine_next = sine_reg;
        cte_prod_next = cte_prod_reg; spd_prod_next = spd_prod_reg;
        los_term_next = los_term_reg; mul_ph_next = mul_ph_reg;
        done_next = 1'b0;
        speed_next = speed_reg; turn_next = turn_reg;
        ax = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        ay = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
        hx = ax[32:1]; hy = ay[32:1];
        // Halve both parts when either reaches 2^31
        halve = ax[32] || ax[31] || ay[32] || ay[31];
        xs = cx_reg >>> it_reg;
        ys = cy_reg >>> it_reg;
        ang = '0; cte_v = '0; acc = '0; tsh = '0; sp_sh = '0; tsum = '0;

        unique case (cmd.phase)
            wtc_pkg::PH_LOAD:
            begin
                if (cmd.start)
                begin
                    dx_next = 33'(wp_x) - 33'(robot_x);
                    dy_next = 33'(wp_y) - 33'(robot_y);
                    mul_ph_next = '0;
                    it_next = '0;
                    norm_next = 1'b0;
                end
                else if (cmd.step)
                begin
                    // Squares are set up one at a time: first x^2
                    halved_next = halve;
                    if (!mul_ph_reg[0])
                    begin
                        rv_next = halve ? 66'(hx) * 66'(hx)
                                        : 66'(ax[31:0]) * 66'(ax[31:0]);
                        mul_ph_next = 2'd1;
                    end
                    else
                    begin
                        rv_next = rv_reg + (halve ? 66'(hy) * 66'(hy)
                                                  : 66'(ay[31:0]) * 66'(ay[31:0]));
                        rr_next = '0;
                        rb_next = 66'(1) << 64;
                        mul_ph_next = 2'd0;
                        done_next = 1'b1;
                    end
                end
            end
            wtc_pkg::PH_ROOT:
            begin
                // One root bit per cycle
                if (cmd.step)
                begin
                    tsum = 67'(rr_reg) + 67'(rb_reg);
                    if (67'(rv_reg) >= tsum)
                    begin
                        rv_next = rv_reg - tsum[65:0];
                        rr_next = 66'((67'(rr_reg) >> 1) + 67'(rb_reg));
                    end
                    else
                    begin
                        rr_next = rr_reg >> 1;
                    end
                    rb_next = rb_reg >> 2;
                    if (rb_reg[0] || rb_reg == 66'd0 || (rb_reg >> 2) == 66'd0)
                    begin
                        done_next = 1'b1;
                        // store distance after saturation
                        if (halved_reg)
                        begin
                            dist_next = (rr_next[32:30] != 3'd0) ? 31'h7FFFFFFF
                                        : {rr_next[29:0], 1'b0};
                        end
                        else
                        begin
                            dist_next = (rr_next[32:31] != 2'd0) ? 31'h7FFFFFFF
                                        : rr_next[30:0];
                        end
                        cx_next = 36'(dx_reg);
                        cy_next = 36'(dy_reg);
                        cz_next = '0;
                        it_next = '0;
                        norm_next = 1'b0;
                    end
                end
            end
            wtc_pkg::PH_ATAN:
            begin
                if (cmd.step)
                begin
                    if (!norm_reg)
                    begin
                        // Scale up one bit a cycle, then fold into right half
                        if (cx_reg == 0 && cy_reg == 0)
                        begin
                            cz_next = '0;
                            done_next = 1'b1;
                        end
                        else if ((cx_reg < 36'sd1073741824 && cx_reg > -36'sd1073741824)
                              && (cy_reg < 36'sd1073741824 && cy_reg > -36'sd1073741824))
                        begin
                            cx_next = cx_reg <<< 1;
                            cy_next = cy_reg <<< 1;
                        end
                        else
                        begin
                            norm_next = 1'b1;
                            if (cx_reg < 0)
                            begin
                                if (cy_reg >= 0)
                                begin
                                    cx_next = cy_reg; cy_next = -cx_reg;
                                    cz_next = 19'(wtc_pkg::ANG_HALF_PI);
                                end
                                else
                                begin
                                    cx_next = -cy_reg; cy_next = cx_reg;
                                    cz_next = -19'(wtc_pkg::ANG_HALF_PI);
                                end
                            end
                        end
                    end
                    else
                    begin
                        if (cy_reg >= 0)
                        begin
                            cx_next = cx_reg + ys; cy_next = cy_reg - xs;
                            cz_next = cz_reg + 19'(wtc_pkg::atan_step(it_reg));
                        end
                        else
                        begin
                            cx_next = cx_reg - ys; cy_next = cy_reg + xs;
                            cz_next = cz_reg - 19'(wtc_pkg::atan_step(it_reg));
                        end
                        it_next = it_reg + 4'd1;
                        if (it_reg == 4'(wtc_pkg::CORDIC_STEPS - 1))
                        begin
                            done_next = 1'b1;
                        end
                    end
                    if (done_next)
                    begin
                        los_next = wtc_pkg::wrap3(cz_next - 19'(robot_heading));
                        ang = 19'(wtc_pkg::wrap3(19'(los_next) - 19'(prev_heading)));
                        sneg_next = 1'b0;
                        if (ang > 19'(wtc_pkg::ANG_HALF_PI))
                        begin
                            ang = ang - 19'(wtc_pkg::ANG_PI); sneg_next = 1'b1;
                        end
                        else if (ang < -19'(wtc_pkg::ANG_HALF_PI))
                        begin
                            ang = ang + 19'(wtc_pkg::ANG_PI); sneg_next = 1'b1;
                        end
                        cx_next = 36'(wtc_pkg::CORDIC_INV_GAIN);
                        cy_next = '0;
                        cz_next = ang;
                        it_next = '0;
                    end
                end
            end
            wtc_pkg::PH_SINE:
            begin
                if (cmd.step)
                begin
                    if (cz_reg >= 0)
                    begin
                        cx_next = cx_reg - ys; cy_next = cy_reg + xs;
                        cz_next = cz_reg - 19'(wtc_pkg::atan_step(it_reg));
                    end
                    else
                    begin
                        cx_next = cx_reg + ys; cy_next = cy_reg - xs;
                        cz_next = cz_reg + 19'(wtc_pkg::atan_step(it_reg));
                    end
                    it_next = it_reg + 4'd1;
                    if (it_reg == 4'(wtc_pkg::CORDIC_STEPS - 1))
                    begin
                        done_next = 1'b1;
                        if (cy_next > 36'(wtc_pkg::SINE_ONE))
                            sine_next = wtc_pkg::SINE_ONE;
                        else if (cy_next < -36'(wtc_pkg::SINE_ONE))
                            sine_next = -wtc_pkg::SINE_ONE;
                        else
                            sine_next = cy_next[16:0];
                        if (sneg_reg) sine_next = -sine_next;
                        mul_ph_next = '0;
                    end
                end
            end
            wtc_pkg::PH_MUL:
            begin
                // Three multiplies, one a cycle
                if (cmd.step)
                begin
                    case (mul_ph_reg)
                        2'd0:
                        begin
                            cte_prod_next = 48'($signed({1'b0, dist_reg})) * 48'(sine_reg);
                            mul_ph_next = 2'd1;
                        end
                        2'd1:
                        begin
                            spd_prod_next = 47'(gain_linear) * 47'(dist_reg);
                            mul_ph_next = 2'd2;
                        end
                        default:
                        begin
                            los_term_next = 37'($signed({1'b0, 17'(gain_bearing_p)
                                                + 17'(gain_bearing_d)})) * 37'(los_reg);
                            mul_ph_next = 2'd0;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            wtc_pkg::PH_FIN:
            begin
                if (cmd.step)
                begin
                    cte_v = 33'(cte_prod_reg >>> 14);
                    acc = (53'(los_term_reg) <<< 3)
                        + 53'($signed({1'b0, 17'(gain_crosstrack_p)
                                + 17'(gain_crosstrack_d)})) * 53'(cte_v);
                    tsh = 38'(acc >>> 15);
                    if (tsh > $signed(38'(turn_limit))) turn_next = 16'(turn_limit);
                    else if (tsh < -$signed(38'(turn_limit))) turn_next = -16'(turn_limit);
                    else turn_next = tsh[15:0];
                    sp_sh = spd_prod_reg >> 12;
                    speed_next = (sp_sh > 47'(speed_limit)) ? speed_limit : sp_sh[30:0];
                    done_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control flags and step counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            mul_ph_reg <= '0;
            it_reg <= '0;
            norm_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            mul_ph_reg <= mul_ph_next;
            it_reg <= it_next;
            norm_reg <= norm_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        dx_reg <= dx_next; dy_reg <= dy_next;
        rv_reg <= rv_next; rr_reg <= rr_next; rb_reg <= rb_next;
        halved_reg <= halved_next; dist_reg <= dist_next;
        cx_reg <= cx_next; cy_reg <= cy_next; cz_reg <= cz_next;
        los_reg <= los_next; sneg_reg <= sneg_next; sine_reg <= sine_next;
        cte_prod_reg <= cte_prod_next; spd_prod_reg <= spd_prod_next;
        los_term_reg <= los_term_next;
        speed_reg <= speed_next; turn_reg <= turn_next;
    end
endmodule
`default_nettype wire

// ===== design/wtc_ctrl.sv =====
// Controller state machine sequencing the datapath.
`default_nettype none
module wtc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             go,        // pose sample needing computation
    input  wire wtc_pkg::dp_stat_t stat,
    output wtc_pkg::dp_cmd_t      cmd,
    output logic                  busy,
    output logic                  finish     // results ready this cycle
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_READ = 8'b0000_0010,
        S_SQ   = 8'b0000_0100,
        S_ROOT = 8'b0000_1000,
        S_ATAN = 8'b0001_0000,
        S_SINE = 8'b0010_0000,
        S_MUL  = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cmd.start = 1'b0;
        cmd.step = 1'b0;
        cmd.phase = wtc_pkg::PH_LOAD;
        finish = 1'b0;
        unique case (state_reg)
            S_IDLE: if (go) state_next = S_READ;
            S_READ:
            begin
                // RAM data valid now
                cmd.start = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.step = !stat.unit_done;
                if (stat.unit_done) state_next = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.phase = wtc_pkg::PH_ROOT;
                cmd.step = !stat.unit_done;
                if (stat.unit_done) state_next = S_ATAN;
            end
            S_ATAN:
            begin
                cmd.phase = wtc_pkg::PH_ATAN;
                cmd.step = !stat.unit_done;
                if (stat.unit_done) state_next = S_SINE;
            end
            S_SINE:
            begin
                cmd.phase = wtc_pkg::PH_SINE;
                cmd.step = !stat.unit_done;
                if (stat.unit_done) state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.phase = wtc_pkg::PH_MUL;
                cmd.step = !stat.unit_done;
                if (stat.unit_done) state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.phase = wtc_pkg::PH_FIN;
                cmd.step = !stat.unit_done;
                if (stat.unit_done)
                begin
                    finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

// ===== design/waypoint_tracking_controller.sv =====
// Waypoint tracking controller: a pose request passes through a RAM read, the squares,
// a bit-serial square root, atan2 by CORDIC vectoring after a normalising shift, sine
// by CORDIC rotation, three multiplies and a final clamp. A pose after the route is done
// is answered directly and a load request gives no result; one request is in work at a
// time, the next is taken the cycle after the result is taken. Reset clears the registers
// to their defaults and the route state; the waypoint table is not cleared.
`default_nettype none
module waypoint_tracking_controller #(
    parameter int MAX_WAYPOINTS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [30:0]       cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              operation,
    input  wire logic [3:0]        slot,
    input  wire logic              final_entry,
    input  wire logic signed [31:0] target_x,
    input  wire logic signed [31:0] target_y,
    input  wire logic signed [31:0] robot_x,
    input  wire logic signed [31:0] robot_y,
    input  wire logic signed [15:0] robot_heading,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [30:0]            speed_cmd,
    output logic signed [15:0]     turn_cmd,
    output logic [4:0]             active_waypoint,
    output logic                   advanced,
    output logic                   finished
);
    localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);

    logic [15:0] g_lin_reg, g_bp_reg, g_bd_reg, g_cp_reg, g_cd_reg;
    logic [30:0] spd_lim_reg, rad_reg;
    logic [14:0] turn_lim_reg;
    logic [CW-1:0] count_reg, idx_reg;
    logic signed [15:0] prev_head_reg;
    logic done_reg;
    logic signed [31:0] rx_reg, ry_reg;
    logic signed [15:0] head_reg;
    logic ov_reg;
    logic [30:0] o_speed_reg;
    logic signed [15:0] o_turn_reg;
    logic [4:0] o_idx_reg;
    logic o_adv_reg, o_fin_reg;

    logic accept, is_load, is_pose, load_ok, trivial, go, busy, finish;
    logic [31:0] wx, wy;
    wtc_pkg::dp_cmd_t cmd;
    wtc_pkg::dp_stat_t stat;
    logic [30:0] wp_dist, speed;
    logic signed [15:0] turn;
    logic reach;
    logic [CW-1:0] idx_inc;

    assign in_stall = busy || ov_reg;
    assign accept = in_valid && !in_stall;
    assign is_load = accept && !operation;
    assign is_pose = accept && operation;
    assign load_ok = is_load && (32'(slot) < 32'(MAX_WAYPOINTS));
    assign trivial = done_reg || (idx_reg >= count_reg);
    assign go = is_pose && !trivial;

    wtc_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_ram_x (
        .clk(clk), .we(load_ok), .waddr(AW'(slot)), .wdata(target_x),
        .raddr(AW'(idx_reg)), .rdata(wx));
    wtc_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_ram_y (
        .clk(clk), .we(load_ok), .waddr(AW'(slot)), .wdata(target_y),
        .raddr(AW'(idx_reg)), .rdata(wy));

    wtc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .go(go), .stat(stat), .cmd(cmd),
        .busy(busy), .finish(finish));

    wtc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .wp_x(wx), .wp_y(wy), .robot_x(rx_reg), .robot_y(ry_reg),
        .robot_heading(head_reg), .prev_heading(prev_head_reg),
        .gain_linear(g_lin_reg), .gain_bearing_p(g_bp_reg), .gain_bearing_d(g_bd_reg),
        .gain_crosstrack_p(g_cp_reg), .gain_crosstrack_d(g_cd_reg),
        .speed_limit(spd_lim_reg), .turn_limit(turn_lim_reg),
        .wp_dist(wp_dist), .speed(speed), .turn(turn));

    assign reach = wp_dist < rad_reg;
    assign idx_inc = idx_reg + CW'(1);

    // Sample operand capture
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rx_reg <= robot_x; ry_reg <= robot_y; head_reg <= robot_heading;
        end
    end

    // Configuration, route state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_lin_reg <= 16'd6144; g_bp_reg <= 16'd12288; g_bd_reg <= 16'd41;
            g_cp_reg <= 16'd41; g_cd_reg <= 16'd41;
            spd_lim_reg <= 31'd98304; turn_lim_reg <= 15'd12868; rad_reg <= 31'd65536;
            count_reg <= '0; idx_reg <= '0; prev_head_reg <= '0; done_reg <= 1'b0;
            ov_reg <= 1'b0;
            o_speed_reg <= '0; o_turn_reg <= '0; o_idx_reg <= '0;
            o_adv_reg <= 1'b0; o_fin_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    wtc_pkg::REG_GAIN_LINEAR: g_lin_reg <= cfg_data[15:0];
                    wtc_pkg::REG_GAIN_BRG_P:  g_bp_reg <= cfg_data[15:0];
                    wtc_pkg::REG_GAIN_BRG_D:  g_bd_reg <= cfg_data[15:0];
                    wtc_pkg::REG_GAIN_CTE_P:  g_cp_reg <= cfg_data[15:0];
                    wtc_pkg::REG_GAIN_CTE_D:  g_cd_reg <= cfg_data[15:0];
                    wtc_pkg::REG_SPEED_LIMIT: spd_lim_reg <= cfg_data;
                    wtc_pkg::REG_TURN_LIMIT:  turn_lim_reg <= cfg_data[14:0];
                    wtc_pkg::REG_ACCEPT_RAD:  rad_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) ov_reg <= 1'b0;
            if (load_ok)
            begin
                if (final_entry) count_reg <= CW'(slot) + CW'(1);
                idx_reg <= '0; done_reg <= 1'b0; prev_head_reg <= '0;
            end
            if (is_pose && trivial)
            begin
                done_reg <= 1'b1;
                ov_reg <= 1'b1;
                o_speed_reg <= '0; o_turn_reg <= '0;
                o_idx_reg <= 5'(idx_reg); o_adv_reg <= 1'b0; o_fin_reg <= 1'b1;
            end
            if (finish)
            begin
                prev_head_reg <= head_reg;
                ov_reg <= 1'b1;
                o_adv_reg <= reach;
                if (reach && idx_inc >= count_reg)
                begin
                    done_reg <= 1'b1;
                    o_speed_reg <= '0; o_turn_reg <= '0; o_fin_reg <= 1'b1;
                end
                else
                begin
                    o_speed_reg <= speed; o_turn_reg <= turn; o_fin_reg <= 1'b0;
                end
                if (reach)
                begin
                    idx_reg <= idx_inc;
                    o_idx_reg <= 5'(idx_inc);
                end
                else
                begin
                    o_idx_reg <= 5'(idx_reg);
                end
            end
        end
    end

    assign out_valid = ov_reg;
    assign speed_cmd = o_speed_reg;
    assign turn_cmd = o_turn_reg;
    assign active_waypoint = o_idx_reg;
    assign advanced = o_adv_reg;
    assign finished = o_fin_reg;

    // No request is taken while a result waits
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> !accept) else $error("request accepted over pending result");
    // Finished results carry zero commands
    a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && finished) |-> (speed_cmd == '0 && turn_cmd == '0))
        else $error("finished result with nonzero command");
    // Turn command stays within its limit
    a_turn_lim: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (turn_cmd <= $signed({1'b0, turn_lim_reg})
                              && turn_cmd >= -$signed({1'b0, turn_lim_reg})))
        else $error("turn command beyond limit");
endmodule
`default_nettype wire

// ===== bench/tb_waypoint_tracking_controller.sv =====
// Self-checking testbench for the waypoint tracking controller: directed and random requests.
module tb_waypoint_tracking_controller;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_POSE = 1'b1;
    localparam int   TABLE_DEPTH = 16;
    localparam int   IDLE_PCT = 38;
    localparam int   HOLD_CYCLES = 500;
    localparam int   SETTLE_CYCLES = 200;
    localparam longint A_PI = 25736;
    localparam longint A_HALF_PI = 12868;
    localparam longint A_TWO_PI = 51472;

    typedef struct {
        logic              op;
        logic [3:0]        slot;
        logic              last;
        logic [31:0]       tx;
        logic [31:0]       ty;
        logic [31:0]       rx;
        logic [31:0]       ry;
        logic [15:0]       hdg;
    } request_t;

    typedef struct {
        logic [30:0]        speed;
        logic signed [15:0] turn;
        logic [4:0]         active;
        logic               adv;
        logic               fin;
    } command_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = wtc_pkg::REG_GAIN_LINEAR;
    logic [30:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic operation = OP_LOAD;
    logic [3:0] slot = '0;
    logic final_entry = 1'b0;
    logic signed [31:0] target_x = '0, target_y = '0, robot_x = '0, robot_y = '0;
    logic signed [15:0] robot_heading = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [30:0] speed_cmd;
    logic signed [15:0] turn_cmd;
    logic [4:0] active_waypoint;
    logic advanced, finished;

    waypoint_tracking_controller u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .slot(slot), .final_entry(final_entry),
        .target_x(target_x), .target_y(target_y),
        .robot_x(robot_x), .robot_y(robot_y), .robot_heading(robot_heading),
        .out_valid(out_valid), .out_stall(out_stall),
        .speed_cmd(speed_cmd), .turn_cmd(turn_cmd), .active_waypoint(active_waypoint),
        .advanced(advanced), .finished(finished)
    );

    always #4 clk = ~clk;

    // Controller model state and register copies
    longint wp_x[TABLE_DEPTH], wp_y[TABLE_DEPTH];
    bit [TABLE_DEPTH-1:0] wp_written;
    int wp_count, wp_cursor;
    longint last_heading;
    bit route_done;
    longint k_lin, k_bp, k_bd, k_cp, k_cd, lim_speed, lim_turn, radius;

    request_t request_queue[$];
    command_t cmd_expected[$];
    int errors = 0;
    int taken_count = 0;
    bit in_took = 1'b0;
    int hold_left = 0;
    bit hold_spent = 1'b0;

    function automatic longint wrap_pi(longint a);
        longint r;
        r = (a + A_PI) % A_TWO_PI;
        if (r < 0) r += A_TWO_PI;
        return r - A_PI;
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint atan_of(int i);
        longint tbl[14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
        return tbl[i];
    endfunction

    // Bearing of (x, y) by CORDIC vectoring after normalising the magnitude
    function automatic longint bearing_to(longint x, longint y);
        longint z, t, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        while ((x < 0 ? -x : x) < (64'sd1 << 30) && (y < 0 ? -y : y) < (64'sd1 << 30)) begin
            x *= 2;
            y *= 2;
        end
        if (x < 0) begin
            if (y >= 0) begin t = x; x = y; y = -t; z = A_HALF_PI; end
            else begin t = x; x = -y; y = t; z = -A_HALF_PI; end
        end
        for (int i = 0; i < 14; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin x += ys; y -= xs; z += atan_of(i); end
            else begin x -= ys; y += xs; z -= atan_of(i); end
        end
        return z;
    endfunction

    // Q1.14 sine by CORDIC rotation
    function automatic longint sine_q14(longint a);
        longint x, y, xs, ys;
        bit neg;
        x = 9949;
        y = 0;
        neg = 1'b0;
        if (a > A_HALF_PI) begin a -= A_PI; neg = 1'b1; end
        else if (a < -A_HALF_PI) begin a += A_PI; neg = 1'b1; end
        for (int i = 0; i < 14; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (a >= 0) begin x -= ys; y += xs; a -= atan_of(i); end
            else begin x += ys; y -= xs; a += atan_of(i); end
        end
        if (y > 16384) y = 16384;
        if (y < -16384) y = -16384;
        return neg ? -y : y;
    endfunction

    // Advance the controller model by one request; returns 1 when a command results
    function automatic bit steer_for_request(request_t rq, output command_t c);
        longint dx, dy, gap, los, cte, speed, acc, turn;
        longint unsigned ax, ay;
        bit adv;
        adv = 1'b0;
        c = '{default: '0};
        if (rq.op == OP_LOAD) begin
            wp_x[rq.slot] = longint'($signed(rq.tx));
            wp_y[rq.slot] = longint'($signed(rq.ty));
            wp_written[rq.slot] = 1'b1;
            if (rq.last) wp_count = int'(rq.slot) + 1;
            wp_cursor = 0;
            route_done = 1'b0;
            last_heading = 0;
            return 1'b0;
        end
        if (route_done || wp_cursor >= wp_count) begin
            route_done = 1'b1;
            c.active = wp_cursor[4:0];
            c.fin = 1'b1;
            return 1'b1;
        end
        dx = wp_x[wp_cursor] - longint'($signed(rq.rx));
        dy = wp_y[wp_cursor] - longint'($signed(rq.ry));
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if (ax >= (64'd1 << 31) || ay >= (64'd1 << 31))
            gap = isqrt((ax >> 1) * (ax >> 1) + (ay >> 1) * (ay >> 1)) << 1;
        else
            gap = isqrt(ax * ax + ay * ay);
        if (gap > 64'h7FFF_FFFF) gap = 64'h7FFF_FFFF;
        los = wrap_pi(bearing_to(dx, dy) - longint'($signed(rq.hdg)));
        cte = (gap * sine_q14(wrap_pi(los - last_heading))) >>> 14;
        speed = (k_lin * gap) >> 12;
        if (speed > lim_speed) speed = lim_speed;
        acc = (k_bp + k_bd) * los * 8 + (k_cp + k_cd) * cte;
        turn = acc >>> 15;
        if (turn > lim_turn) turn = lim_turn;
        if (turn < -lim_turn) turn = -lim_turn;
        last_heading = longint'($signed(rq.hdg));
        if (gap < radius) begin
            adv = 1'b1;
            wp_cursor++;
            if (wp_cursor >= wp_count) route_done = 1'b1;
        end
        if (route_done) begin
            speed = 0;
            turn = 0;
        end
        c.speed = speed[30:0];
        c.turn = turn[15:0];
        c.active = wp_cursor[4:0];
        c.adv = adv;
        c.fin = route_done;
        return 1'b1;
    endfunction

    // Queue a request and its expected command, if any
    task automatic issue(request_t rq);
        command_t c;
        if (steer_for_request(rq, c)) cmd_expected = {cmd_expected, c};
        request_queue = {request_queue, rq};
    endtask

    task automatic issue_load(int s, bit last, logic [31:0] x, logic [31:0] y);
        request_t rq;
        rq = '{op: OP_LOAD, slot: s[3:0], last: last, tx: x, ty: y,
               rx: $urandom, ry: $urandom, hdg: 16'($urandom)};
        issue(rq);
    endtask

    task automatic issue_pose(logic [31:0] x, logic [31:0] y, logic [15:0] h);
        request_t rq;
        rq = '{op: OP_POSE, slot: 4'($urandom), last: 1'($urandom),
               tx: $urandom, ty: $urandom, rx: x, ry: y, hdg: h};
        issue(rq);
    endtask

    // Wait until the block is quiet: nothing queued, nothing owed, loads settled
    task automatic wait_quiet();
        while (request_queue.size() != 0 || in_valid || cmd_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[30:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            wtc_pkg::REG_GAIN_LINEAR: k_lin = v & 16'hFFFF;
            wtc_pkg::REG_GAIN_BRG_P:  k_bp = v & 16'hFFFF;
            wtc_pkg::REG_GAIN_BRG_D:  k_bd = v & 16'hFFFF;
            wtc_pkg::REG_GAIN_CTE_P:  k_cp = v & 16'hFFFF;
            wtc_pkg::REG_GAIN_CTE_D:  k_cd = v & 16'hFFFF;
            wtc_pkg::REG_SPEED_LIMIT: lim_speed = v & 31'h7FFF_FFFF;
            wtc_pkg::REG_TURN_LIMIT:  lim_turn = v & 15'h7FFF;
            default:                  radius = v & 31'h7FFF_FFFF;
        endcase
    endtask

    task automatic set_regs(longint gl, longint gbp, longint gbd, longint gcp, longint gcd,
                            longint sl, longint tl, longint ar);
        wait_quiet();
        write_reg(wtc_pkg::REG_GAIN_LINEAR, gl);
        write_reg(wtc_pkg::REG_GAIN_BRG_P, gbp);
        write_reg(wtc_pkg::REG_GAIN_BRG_D, gbd);
        write_reg(wtc_pkg::REG_GAIN_CTE_P, gcp);
        write_reg(wtc_pkg::REG_GAIN_CTE_D, gcd);
        write_reg(wtc_pkg::REG_SPEED_LIMIT, sl);
        write_reg(wtc_pkg::REG_TURN_LIMIT, tl);
        write_reg(wtc_pkg::REG_ACCEPT_RAD, ar);
    endtask

    function automatic logic [31:0] coord();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    endfunction

    function automatic logic [15:0] heading();
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 51471) - 25736);
    endfunction

    // Every slot below s already holds a waypoint
    function automatic bit slots_below_written(int s);
        for (int i = 0; i < s; i++)
            if (!wp_written[i]) return 1'b0;
        return 1'b1;
    endfunction

    // One phase of random traffic: mostly routes followed by near-waypoint poses
    task automatic random_phase(int count);
        int n, s, span;
        logic [31:0] ox, oy;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 6) begin
                n = $urandom_range(1, TABLE_DEPTH);
                if ($urandom_range(0, 3) != 0) n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    issue_load(i, i == n - 1, coord(), coord());
                k += n;
            end
            else if ($urandom_range(0, 99) < 5) begin
                s = $urandom_range(0, TABLE_DEPTH - 1);
                issue_load(s, slots_below_written(s) && ($urandom_range(0, 1) == 1),
                           coord(), coord());
            end
            else if (route_done || wp_cursor >= wp_count || $urandom_range(0, 9) == 0)
                issue_pose($urandom, $urandom, heading());
            else begin
                span = (radius > 64'sd2 && radius < 64'sd1 << 24) ? int'(radius) * 2 : 1 << 18;
                ox = $urandom_range(0, span) - span / 2;
                oy = $urandom_range(0, span) - span / 2;
                issue_pose(wp_x[wp_cursor][31:0] + ox, wp_y[wp_cursor][31:0] + oy, heading());
            end
        end
    endtask

    function automatic bit quiet_stretch();
        return taken_count >= 600 && taken_count < 1000;
    endfunction

    // Request driver: presents the next pending request at the falling edge
    always @(posedge clk) begin
        in_took <= in_valid && !in_stall;
        if (in_valid && !in_stall) taken_count <= taken_count + 1;
    end

    always @(negedge clk) begin
        request_t rq;
        bit offer;
        if (rst_n && (!in_valid || in_took)) begin
            offer = request_queue.size() != 0 &&
                    (quiet_stretch() || $urandom_range(0, 99) >= IDLE_PCT);
            if (offer) begin
                rq = request_queue.pop_front();
                operation <= rq.op;
                slot <= rq.slot;
                final_entry <= rq.last;
                target_x <= rq.tx;
                target_y <= rq.ty;
                robot_x <= rq.rx;
                robot_y <= rq.ry;
                robot_heading <= rq.hdg;
            end
            in_valid <= offer;
        end
    end

    // Command receiver stall, with one long hold-off to back the block up
    always @(negedge clk) begin
        if (!hold_spent && taken_count >= 300) begin
            hold_spent <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !quiet_stretch() && $urandom_range(0, 99) < IDLE_PCT;
    end

    // Command checker
    always @(posedge clk) begin
        command_t c;
        if (rst_n && out_valid && !out_stall) begin
            if (cmd_expected.size() == 0) begin
                $error("unexpected command: speed_cmd %0d turn_cmd %0d", speed_cmd, turn_cmd);
                errors++;
            end
            else begin
                c = cmd_expected.pop_front();
                if (speed_cmd !== c.speed) begin
                    $error("speed_cmd expected %0d actual %0d", c.speed, speed_cmd);
                    errors++;
                end
                if (turn_cmd !== c.turn) begin
                    $error("turn_cmd expected %0d actual %0d", c.turn, turn_cmd);
                    errors++;
                end
                if (active_waypoint !== c.active) begin
                    $error("active_waypoint expected %0d actual %0d", c.active, active_waypoint);
                    errors++;
                end
                if (advanced !== c.adv) begin
                    $error("advanced expected %0d actual %0d", c.adv, advanced);
                    errors++;
                end
                if (finished !== c.fin) begin
                    $error("finished expected %0d actual %0d", c.fin, finished);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("FAIL waypoint_tracking_controller");
        $finish;
    end

    initial begin
        k_lin = 6144; k_bp = 12288; k_bd = 41; k_cp = 41; k_cd = 41;
        lim_speed = 98304; lim_turn = 12868; radius = 65536;
        wp_written = '0; wp_count = 0; wp_cursor = 0; last_heading = 0; route_done = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty route, extreme coordinates and headings, radius edge, finish
        issue_pose(32'h0, 32'h0, 16'h0);
        issue_load(0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
        issue_load(1, 1'b0, 32'h0, 32'h0);
        issue_load(15, 1'b0, 32'hFFFF_FFFF, 32'h1);
        issue_load(2, 1'b1, 32'd100 << 16, -(32'd50 << 16));
        issue_pose(32'h8000_0000, 32'h7FFF_FFFF, 16'sd25735);
        issue_pose(32'h8000_0000, 32'h8000_0000, -16'sd25736);
        issue_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF);
        issue_pose(32'd3 << 16, -(32'd4 << 16), 16'h8000);
        issue_pose(32'h0, 32'h0, 16'h0);
        issue_pose(32'd99 << 16, -(32'd50 << 16), 16'h0);
        issue_pose(32'd100 << 16, -(32'd50 << 16) + 32'd1, 16'sd12868);
        issue_pose(32'h1234, 32'h5678, -16'sd12868);
        issue_load(3, 1'b1, 32'h0001_0000, -32'h0001_0000);
        issue_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'h0);
        issue_pose(32'h0, 32'h0, 16'sd100);

        // Random phases across register settings, extremes included
        random_phase(250);
        set_regs(0, 0, 0, 0, 0, 0, 0, 0);
        random_phase(200);
        set_regs(65535, 65535, 65535, 65535, 65535, 31'h7FFF_FFFF, 25736, 31'h7FFF_FFFF);
        random_phase(150);
        set_regs(65535, 65535, 65535, 65535, 65535, 31'h7FFF_FFFF, 25736, 65536);
        random_phase(300);
        set_regs(6144, 12288, 41, 41, 41, 98304, 12868, 1 << 18);
        random_phase(350);
        for (int p = 0; p < 3; p++) begin
            set_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 32'h7FFF_FFFF),
                     $urandom_range(0, 25736), $urandom_range(1 << 12, 1 << 20));
            random_phase(250);
        end

        wait_quiet();
        if (errors == 0)
            $display("PASS waypoint_tracking_controller");
        else
            $display("FAIL waypoint_tracking_controller");
        $finish;
    end

endmodule
